// ===== rtl/core/fwht_pkg.sv =====
// Package for the fast Walsh-Hadamard transform core.
// Holds the sequencer state type, the per-cell control word and register constants.
// No dependencies.
`default_nettype none

package fwht_pkg;

    localparam int LEN_LOG2_W = 3;
    localparam logic [LEN_LOG2_W-1:0] LEN_LOG2_RESET = 3'd6;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } fwht_state_t;

    typedef struct packed {
        logic advance;
        logic butterfly;
        logic upper_half;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/fwht_sample_if.sv =====
// Input channel of the transform core: one signed sample per word.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface fwht_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fwht_coef_if.sv =====
// Output channel of the transform core: coefficient, index and last mark per word.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface fwht_coef_if #(
    parameter int COEF_BITS  = 22,
    parameter int INDEX_BITS = 6
);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coefficient;
    logic [INDEX_BITS-1:0]       coef_index;
    logic                        last_coef;

    modport source (output valid, output coefficient, output coef_index, output last_coef,
                    input ready);
    modport sink (input valid, input coefficient, input coef_index, input last_coef,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fwht_cfg_if.sv =====
// Configuration write channel carrying the length_log2 register value.
// Depends on fwht_pkg for the register width.
`default_nettype none

interface fwht_cfg_if
    import fwht_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [LEN_LOG2_W-1:0] length_log2;

    modport source (output valid, output length_log2, input ready);
    modport sink (input valid, input length_log2, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fwht_cell.sv =====
// One delay-feedback butterfly cell of the transform chain.
// Depends on fwht_pkg for the cell control word.
`default_nettype none

module fwht_cell
    import fwht_pkg::*;
#(
    parameter int WIDTH      = 22,
    parameter int DEPTH_LOG2 = 0
) (
    input  wire logic                    clk,
    input  wire cell_ctrl_t              ctrl,
    input  wire logic signed [WIDTH-1:0] data_in,
    output logic signed [WIDTH-1:0]      data_out
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic signed [WIDTH-1:0] fifo_reg [DEPTH];
    logic signed [WIDTH-1:0] out_reg;
    logic signed [WIDTH-1:0] out_next;
    logic signed [WIDTH-1:0] fifo_next;
    logic signed [WIDTH-1:0] head;

    always_comb
    begin
        head = fifo_reg[DEPTH-1];
        if (!ctrl.butterfly)
        begin
            out_next  = data_in;
            fifo_next = data_in;
        end
        else if (!ctrl.upper_half)
        begin
            out_next  = head;
            fifo_next = data_in;
        end
        else
        begin
            out_next  = head + data_in;
            fifo_next = head - data_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            out_reg     <= out_next;
            fifo_reg[0] <= fifo_next;
            for (int i = 1; i < DEPTH; i++)
            begin
                fifo_reg[i] <= fifo_reg[i-1];
            end
        end
    end

    assign data_out = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fast_walsh_hadamard_transform_core.sv =====
// Fast Walsh-Hadamard transform core: a chain of butterfly cells and its sequencer.
// Depends on fwht_pkg, fwht_cell and the three channel interfaces.
// A vector of n = 2^length_log2 samples is taken one word per cycle while samples.valid is high.
// The first coefficient passes through every cell of the chain and then the output register;
// after it, one coefficient per cycle while coefs.ready does not hold the output register.
// Reset clears the sequencer and output valid; length_log2 resets to 6.
`default_nettype none

module fast_walsh_hadamard_transform_core
    import fwht_pkg::*;
#(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input wire logic      clk,
    input wire logic      rst_n,
    fwht_cfg_if.sink      cfg,
    fwht_sample_if.sink   samples,
    fwht_coef_if.source   coefs
);

    localparam int LOG_MAX = $clog2(MAX_POINTS + 1) - 1;
    localparam int STAGES  = LOG_MAX;
    localparam int COEF_W  = SAMPLE_BITS + LOG_MAX;
    localparam int IDX_W   = LOG_MAX;
    localparam int CNT_W   = $clog2(2 * (1 << LOG_MAX) + LOG_MAX);

    fwht_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        t_reg, t_next;
    logic [LEN_LOG2_W-1:0]   length_reg;
    logic [LEN_LOG2_W-1:0]   len_eff;
    logic [CNT_W-1:0]        vec_len;
    logic [CNT_W-1:0]        first_t;
    logic [CNT_W-1:0]        rel_out;
    logic                    produce;
    logic                    is_last;
    logic                    adv;
    logic                    capture;
    logic                    out_free;

    logic                    out_valid_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    last_reg;

    logic signed [COEF_W-1:0] link [STAGES+1];
    cell_ctrl_t               cell_ctrl [STAGES];

    always_comb
    begin
        if (32'(length_reg) > LOG_MAX)
        begin
            len_eff = LEN_LOG2_W'(LOG_MAX);
        end
        else
        begin
            len_eff = length_reg;
        end
    end

    assign vec_len  = CNT_W'(1) << len_eff;
    assign first_t  = vec_len - CNT_W'(1) + CNT_W'(STAGES);
    assign rel_out  = t_reg - first_t;
    assign produce  = (state_reg == ST_DRAIN) && (t_reg >= first_t);
    assign is_last  = (t_reg == first_t + vec_len - CNT_W'(1));
    assign out_free = !out_valid_reg || coefs.ready;

    assign samples.ready = (state_reg == ST_LOAD);
    assign cfg.ready     = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        adv        = 1'b0;
        capture    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (samples.valid)
                begin
                    adv    = 1'b1;
                    t_next = t_reg + CNT_W'(1);
                    if (t_reg == vec_len - CNT_W'(1))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    adv    = 1'b1;
                    t_next = t_reg + CNT_W'(1);
                    if (produce)
                    begin
                        capture = 1'b1;
                        if (is_last)
                        begin
                            state_next = ST_LOAD;
                            t_next     = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                t_next     = '0;
            end
        endcase
        if (cfg.valid)
        begin
            state_next = ST_LOAD;
            t_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            t_reg         <= '0;
            length_reg    <= LEN_LOG2_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            if (cfg.valid)
            begin
                length_reg <= cfg.length_log2;
            end
            if (capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (coefs.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            coef_reg <= link[STAGES];
            idx_reg  <= rel_out[IDX_W-1:0];
            last_reg <= is_last;
        end
    end

    assign link[0] = (state_reg == ST_LOAD)
                   ? {{LOG_MAX{samples.sample[SAMPLE_BITS-1]}}, samples.sample}
                   : '0;

    for (genvar j = 0; j < STAGES; j++)
    begin : g_cell
        localparam int OFFSET = (1 << j) - 1 + j;
        logic [CNT_W-1:0] rel_idx;

        assign rel_idx                 = t_reg - CNT_W'(OFFSET);
        assign cell_ctrl[j].advance    = adv;
        assign cell_ctrl[j].butterfly  = (j < int'(len_eff));
        assign cell_ctrl[j].upper_half = rel_idx[j];

        fwht_cell #(
            .WIDTH      (COEF_W),
            .DEPTH_LOG2 (j)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl[j]),
            .data_in  (link[j]),
            .data_out (link[j+1])
        );
    end

    assign coefs.valid       = out_valid_reg;
    assign coefs.coefficient = coef_reg;
    assign coefs.coef_index  = idx_reg;
    assign coefs.last_coef   = last_reg;

`ifndef ASSERT_OFF
    a_no_capture_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |-> !capture)
        else $error("Coefficient captured while a sample was being loaded.");

    a_last_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (capture && is_last) |=> (state_reg == ST_LOAD))
        else $error("Sequencer did not return to loading after the last coefficient.");

    a_load_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (t_reg < vec_len))
        else $error("Load count ran past the vector length.");

    a_drain_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (t_reg <= first_t + vec_len - CNT_W'(1)))
        else $error("Drain count ran past the last coefficient.");
`endif

endmodule

`default_nettype wire
